// ----- src/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    // Request codes
    localparam logic [1:0] REQ_APPEND        = 2'd0;
    localparam logic [1:0] REQ_APPEND_FINISH = 2'd1;
    localparam logic [1:0] REQ_FINISH        = 2'd2;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;
    localparam int         QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_t;

    // One message word for the compression engine; last marks the final block
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } qword_t;

    // Queue status seen by a consumer
    typedef struct packed {
        logic   empty;
        qword_t head;
    } qstat_t;

    localparam logic [31:0] IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ----- src/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with a finish request and an eight-word digest.
// ----------------------------------------------------------------------------
// Bytes are taken at most one per cycle and packed into words that queue up
// for the compression engine, which runs one round per cycle. A block costs
// the engine 64 rounds and one chain add, but its first 16 rounds wait on
// words from the four-word queue; bytes of the next block can queue up while
// the engine runs its later rounds, and the input stalls whenever the queue
// is full. A finish request holds the input while the padding and length
// words are queued: 3 to 18 words, one per cycle while the queue has room and
// longer while the engine drains it. The digest leaves through an output
// register as eight transactions, word 0 first, the first of them presented
// once the last round of the final block and its chain add are done.
module sha256_stream_hasher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sha_pkg::req_t     req,
    output logic              dig_valid,
    input  logic              dig_stall,
    output sha_pkg::dig_t     dig
);

    logic              push, full, pop;
    sha_pkg::qword_t   push_data;
    sha_pkg::qstat_t   stat;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    sha_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .stat      (stat)
    );

    sha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop       (pop),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

endmodule

// ----- src/sha_front.sv -----
// ----------------------------------------------------------------------------
// sha_front
// Packs message bytes into big-endian words, counts message bits and
// generates the padding and length words on a finish request.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sha_pkg::req_t     req,
    output logic              push,
    output sha_pkg::qword_t   push_data,
    input  logic              full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PADW = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  bcnt_reg, bcnt_next;
    logic [3:0]  widx_reg, widx_next;
    logic [63:0] bits_reg, bits_next;
    logic        len_ok_reg, len_ok_next;
    logic        accept;
    logic        has_byte;

    assign req_stall = (state_reg != ST_IDLE) || full;
    assign accept    = req_valid && !req_stall;
    assign has_byte  = (req.req_type == sha_pkg::REQ_APPEND) ||
                       (req.req_type == sha_pkg::REQ_APPEND_FINISH);

    // Absorb bytes, then walk the padding words
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        bcnt_next   = bcnt_reg;
        widx_next   = widx_reg;
        bits_next   = bits_reg;
        len_ok_next = len_ok_reg;
        push        = 1'b0;
        push_data   = '{word: 32'd0, last: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && has_byte)
                begin
                    bits_next = bits_reg + 64'd8;
                    acc_next  = {acc_reg[15:0], req.data_byte};
                    bcnt_next = bcnt_reg + 2'd1;
                    if (bcnt_reg == 2'd3)
                    begin
                        push      = 1'b1;
                        push_data = '{word: {acc_reg, req.data_byte}, last: 1'b0};
                        widx_next = widx_reg + 4'd1;
                    end
                end
                if (accept && (req.req_type == sha_pkg::REQ_APPEND_FINISH ||
                               req.req_type == sha_pkg::REQ_FINISH))
                begin
                    state_next = ST_PADW;
                end
            end
            ST_PADW:
            begin
                unique case (bcnt_reg)
                    2'd0: push_data.word = {sha_pkg::PAD_BYTE, 24'd0};
                    2'd1: push_data.word = {acc_reg[7:0], sha_pkg::PAD_BYTE, 16'd0};
                    2'd2: push_data.word = {acc_reg[15:0], sha_pkg::PAD_BYTE, 8'd0};
                    default: push_data.word = {acc_reg, sha_pkg::PAD_BYTE};
                endcase
                if (!full)
                begin
                    push        = 1'b1;
                    // A pad word in slot 14 or 15 pushes the length into a block of its own; only slot 14
                    // clears len_ok, since a pad word in slot 15 closes the block, so the next one is it
                    len_ok_next = (widx_reg != sha_pkg::LEN_HI_IDX);
                    widx_next   = widx_reg + 4'd1;
                    bcnt_next   = 2'd0;
                    state_next  = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (len_ok_reg && widx_reg == sha_pkg::LEN_HI_IDX)
                begin
                    push_data.word = bits_reg[63:32];
                end
                else if (len_ok_reg && widx_reg == sha_pkg::LEN_LO_IDX)
                begin
                    push_data = '{word: bits_reg[31:0], last: 1'b1};
                end
                if (!full)
                begin
                    push      = 1'b1;
                    widx_next = widx_reg + 4'd1;
                    if (widx_reg == sha_pkg::LEN_LO_IDX)
                    begin
                        len_ok_next = 1'b1;
                        if (len_ok_reg)
                        begin
                            bits_next  = 64'd0;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bcnt_reg   <= 2'd0;
            widx_reg   <= 4'd0;
            bits_reg   <= 64'd0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bcnt_reg   <= bcnt_next;
            widx_reg   <= widx_next;
            bits_reg   <= bits_next;
            len_ok_reg <= len_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("front pushed into a full queue");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == ST_IDLE) else $error("request taken while padding");
    a_len_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.last) |=> bits_reg == 64'd0)
        else $error("bit count not cleared after length word");

endmodule

// ----- src/sha_queue.sv -----
// ----------------------------------------------------------------------------
// sha_queue
// Small word queue between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sha_pkg::qword_t   push_data,
    output logic              full,
    input  logic              pop,
    output sha_pkg::qstat_t   stat
);

    localparam int PW = $clog2(sha_pkg::QUEUE_DEPTH);

    sha_pkg::qword_t mem [sha_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   count_reg;

    assign full       = (count_reg == (PW+1)'(sha_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.head  = mem[rptr_reg];

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ----- src/sha_back.sv -----
// ----------------------------------------------------------------------------
// sha_back
// Compression engine: one round per cycle when its word is ready, rolling
// 16-word schedule, chain update after round 63, output-registered digest.
// ----------------------------------------------------------------------------
module sha_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::qstat_t   stat,
    output logic              pop,
    output logic              dig_valid,
    input  logic              dig_stall,
    output sha_pkg::dig_t     dig
);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_ADD = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0]  state_reg;
    logic [5:0]  t_reg;
    logic [2:0]  oidx_reg;
    logic        last_reg;
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] chain_reg [8];
    logic        dvalid_reg;
    sha_pkg::dig_t dig_reg;

    logic [31:0] s [8];
    logic [31:0] w_sched, w_t, t1, t2, ch, mj;
    logic        need_word, go, load_out;

    assign need_word = (t_reg < 6'd16);
    assign go        = (state_reg == ST_RUN) && (!need_word || !stat.empty);
    assign pop       = go && need_word;
    assign load_out  = (state_reg == ST_OUT) && (!dvalid_reg || !dig_stall);
    assign dig_valid = dvalid_reg;
    assign dig       = dig_reg;

    // Round datapath
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            s[i] = (t_reg == 6'd0) ? chain_reg[i] : v_reg[i];
        end
        w_sched = sha_pkg::small_sigma1(w_reg[14]) + w_reg[9] +
                  sha_pkg::small_sigma0(w_reg[1]) + w_reg[0];
        w_t = need_word ? stat.head.word : w_sched;
        ch  = (s[4] & s[5]) ^ (~s[4] & s[6]);
        mj  = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
        t1  = s[7] + sha_pkg::big_sigma1(s[4]) + ch + sha_pkg::RK[t_reg] + w_t;
        t2  = sha_pkg::big_sigma0(s[0]) + mj;
    end

    // Working variables and schedule
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= s[0];
            v_reg[2] <= s[1];
            v_reg[3] <= s[2];
            v_reg[4] <= s[3] + t1;
            v_reg[5] <= s[4];
            v_reg[6] <= s[5];
            v_reg[7] <= s[6];
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_t;
        end
        if (load_out)
        begin
            dig_reg <= '{digest_word: chain_reg[oidx_reg], word_index: oidx_reg,
                         last_word: (oidx_reg == 3'd7)};
        end
    end

    // Sequence rounds, chain update and digest output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            t_reg      <= 6'd0;
            oidx_reg   <= 3'd0;
            last_reg   <= 1'b0;
            dvalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::IV[i];
            end
        end
        else
        begin
            if (load_out)
            begin
                dvalid_reg <= 1'b1;
            end
            else if (!dig_stall)
            begin
                dvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN:
                begin
                    if (go)
                    begin
                        t_reg <= t_reg + 6'd1;
                        if (t_reg == 6'd15)
                        begin
                            last_reg <= stat.head.last;
                        end
                        if (t_reg == 6'd63)
                        begin
                            state_reg <= ST_ADD;
                        end
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                    state_reg <= last_reg ? ST_OUT : ST_RUN;
                end
                ST_OUT:
                begin
                    if (load_out)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= sha_pkg::IV[i];
                            end
                            last_reg  <= 1'b0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    a_pop_round: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_RUN && t_reg < 6'd16))
        else $error("word popped outside the load rounds");
    a_chain_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && oidx_reg == 3'd7) |=> chain_reg[0] == sha_pkg::IV[0])
        else $error("chain not reinitialised after digest");
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        dvalid_reg |-> (dig_reg.last_word == (dig_reg.word_index == 3'd7)))
        else $error("last flag disagrees with word index");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Byte-stream SHA-256 hasher check: directed and random messages, digests
// compared word by word against an in-bench hash model.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    sha_pkg::req_t req;
    logic dig_valid;
    logic dig_stall;
    sha_pkg::dig_t dig;

    sha256_stream_hasher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    // Hash model state
    logic [31:0] hash_words [8];
    logic [7:0]  msg_block [64];
    logic [5:0]  pend_bytes;
    logic [63:0] bit_total;

    sha_pkg::dig_t digest_q [$];
    int   fail_count;
    int   idle_cycles;
    bit   calm;      // no idling on either side
    bit   finishing;

    // Directed table; a row with a known digest word 0 carries it
    typedef struct {
        logic [1:0]  rtype;
        logic [7:0]  rbyte;
        bit          known;
        logic [31:0] word0;
    } row_t;

    row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] rot(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run one 64-round compression over msg_block into hash_words
    task automatic crunch_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, mj;
        begin
            for (int t = 0; t < 16; t++)
                w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2],
                        msg_block[4*t+3]};
            for (int t = 16; t < 64; t++)
            begin
                s0 = rot(w[t-15], 7) ^ rot(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rot(w[t-2], 17) ^ rot(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
            for (int i = 0; i < 8; i++)
                v[i] = hash_words[i];
            for (int t = 0; t < 64; t++)
            begin
                ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
                mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25)) + ch
                     + ROUND_K[t] + w[t];
                t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22)) + mj;
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash_words[i] = hash_words[i] + v[i];
        end
    endtask

    task automatic restart_hash();
        begin
            for (int i = 0; i < 8; i++)
                hash_words[i] = INIT_HASH[i];
            pend_bytes = '0;
            bit_total  = '0;
        end
    endtask

    // Advance the hash model by one accepted request
    task automatic hash_request(input sha_pkg::req_t r);
        logic [5:0] pos;
        sha_pkg::dig_t d;
        begin
            if (r.req_type != 2'd3)
            begin
                if (r.req_type != sha_pkg::REQ_FINISH)
                begin
                    msg_block[pend_bytes] = r.data_byte;
                    bit_total  = bit_total + 64'd8;
                    pend_bytes = pend_bytes + 6'd1;
                    if (pend_bytes == 6'd0)
                        crunch_block();
                end
                if (r.req_type != sha_pkg::REQ_APPEND)
                begin
                    pos = pend_bytes;
                    msg_block[pos] = sha_pkg::PAD_BYTE;
                    for (int i = pos + 1; i < 64; i++)
                        msg_block[i] = 8'h00;
                    if (pos >= 6'd56)
                    begin
                        crunch_block();
                        for (int i = 0; i < 64; i++)
                            msg_block[i] = 8'h00;
                    end
                    for (int i = 0; i < 8; i++)
                        msg_block[56 + i] = bit_total[63 - 8*i -: 8];
                    crunch_block();
                    for (int j = 0; j < 8; j++)
                    begin
                        d.digest_word = hash_words[j];
                        d.word_index  = j[2:0];
                        d.last_word   = (j == 7);
                        digest_q.push_back(d);
                    end
                    restart_hash();
                end
            end
        end
    endtask

    // Present one request and hold it until accepted; valid stays up so the
    // next request can follow at once
    task automatic send_request(input logic [1:0] rtype, input logic [7:0] rbyte);
        begin
            while (!calm && $urandom_range(99) < 24)
            begin
                req_valid <= 1'b0;
                req       <= '{req_type: 2'($urandom), data_byte: 8'($urandom)};
                @(negedge clk);
            end
            req_valid <= 1'b1;
            req       <= '{req_type: rtype, data_byte: rbyte};
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            hash_request('{req_type: rtype, data_byte: rbyte});
            @(negedge clk);
        end
    endtask

    // Drive the digest stall at random
    always @(negedge clk)
    begin
        if (!calm)
            dig_stall <= ($urandom_range(99) < 24);
        else
            dig_stall <= 1'b0;
    end

    // Compare each digest transaction with the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && dig_valid && !dig_stall)
        begin
            if (digest_q.size() == 0)
            begin
                $display("%0t digest word with none expected: actual %h/%0d/%0d",
                         $time, dig.digest_word, dig.word_index, dig.last_word);
                fail_count++;
            end
            else
            begin
                if (dig !== digest_q[0])
                begin
                    $display("%0t digest mismatch: expected %h/%0d/%0d actual %h/%0d/%0d",
                             $time, digest_q[0].digest_word, digest_q[0].word_index,
                             digest_q[0].last_word, dig.digest_word, dig.word_index,
                             dig.last_word);
                    fail_count++;
                end
                void'(digest_q.pop_front());
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (dig_valid && !dig_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic add_row(input logic [1:0] t, input logic [7:0] b,
                           input bit k = 0, input logic [31:0] w0 = '0);
        row_t r;
        begin
            r.rtype = t; r.rbyte = b; r.known = k; r.word0 = w0;
            dir_rows.push_back(r);
        end
    endtask

    // Send one random message, sized near the padding edges half of the time
    task automatic random_message(output int sent);
        int len;
        int pick;
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                len = $urandom_range(52, 70);
            else if (pick < 5)
                len = $urandom_range(120, 130);
            else
                len = $urandom_range(0, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(29) == 0)
                    send_request(2'd3, 8'($urandom));
                send_request(sha_pkg::REQ_APPEND, 8'($urandom));
            end
            if ($urandom_range(1))
                send_request(sha_pkg::REQ_APPEND_FINISH, 8'($urandom));
            else
                send_request(sha_pkg::REQ_FINISH, 8'($urandom));
            sent = len + 1;
        end
    endtask

    initial
    begin
        int total;
        int n;
        int wait_cycles;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        dig_stall   = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
        restart_hash();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, "abc", unused code, extreme bytes, edges
        add_row(sha_pkg::REQ_FINISH, 8'hFF, 1, 32'he3b0c442);
        add_row(sha_pkg::REQ_APPEND, "a");
        add_row(sha_pkg::REQ_APPEND, "b");
        add_row(sha_pkg::REQ_APPEND_FINISH, "c", 1, 32'hba7816bf);
        add_row(2'd3, 8'hFF);
        add_row(sha_pkg::REQ_APPEND_FINISH, 8'h00);
        add_row(sha_pkg::REQ_APPEND, 8'hFF);
        add_row(sha_pkg::REQ_APPEND, 8'h55);
        add_row(sha_pkg::REQ_APPEND_FINISH, 8'hAA);
        add_row(2'd3, 8'h00);
        add_row(sha_pkg::REQ_FINISH, 8'h00, 1, 32'he3b0c442);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].known)
                hash_words[0] = hash_words[0];
            send_request(dir_rows[i].rtype, dir_rows[i].rbyte);
            if (dir_rows[i].known && dir_rows[i].rtype != 2'd3)
            begin
                n = digest_q.size() - 8;
                if (digest_q[n].digest_word !== dir_rows[i].word0)
                begin
                    $display("%0t table digest: expected %h actual %h",
                             $time, dir_rows[i].word0, digest_q[n].digest_word);
                    fail_count++;
                end
            end
        end

        // Messages of 55, 56, 63 and 64 bytes around the length boundary
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < (k == 0 ? 55 : k == 1 ? 56 : k == 2 ? 63 : 64); i++)
                send_request(sha_pkg::REQ_APPEND, 8'($urandom));
            send_request(sha_pkg::REQ_FINISH, 8'h00);
        end

        // Random messages, with a calm stretch in the middle
        total = 0;
        while (total < 140)
        begin
            calm = (total > 40 && total < 100);
            random_message(n);
            total += n;
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        wait_cycles = 0;
        while (digest_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && digest_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
